// ===== rtl/sha1he_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared types and constants: queue entry, queue depth, hash constants.
// ----------------------------------------------------------------------------
package sha1he_pkg;

    localparam int unsigned C_QDEPTH = 4;
    localparam int unsigned C_QAW    = $clog2(C_QDEPTH);

    localparam logic [7:0] C_PAD_BYTE = 8'h80;

    localparam logic [31:0] C_H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] C_K0 = 32'h5A827999;
    localparam logic [31:0] C_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] C_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] C_K3 = 32'hCA62C1D6;

    // one schedule word on its way to the compression core
    typedef struct packed {
        logic [31:0] word;
        logic        is_end;
    } t_cmd;

endpackage

// ===== rtl/sha1he_ifs.sv =====
// ----------------------------------------------------------------------------
// SHA-1 engine channels
// Valid/ready stream interfaces for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha1he_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       is_last;

    modport source (output valid, data_byte, byte_valid, is_last, input ready);
    modport sink   (input valid, data_byte, byte_valid, is_last, output ready);
endinterface

interface sha1he_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        last_word;

    modport source (output valid, digest_word, last_word, input ready);
    modport sink   (input valid, digest_word, last_word, output ready);
endinterface

// ===== rtl/sha1he_front.sv =====
// ----------------------------------------------------------------------------
// SHA-1 engine front end
// Packs message bytes into big-endian words, counts the length and
// generates the pad, zero fill and bit-length words at end of message.
// ----------------------------------------------------------------------------
module sha1he_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha1he_byte_if.sink         i_byte,
    output logic                o_cmd_valid,
    output sha1he_pkg::t_cmd    o_cmd,
    input  logic                i_cmd_ready
);
    import sha1he_pkg::*;

    typedef enum logic [2:0] {F_DATA, F_PAD, F_ZERO, F_LENHI, F_LENLO} t_fstate;

    t_fstate      r_state;
    logic [23:0]  r_acc;
    logic [1:0]   r_bpos;
    logic [3:0]   r_widx;
    logic [60:0]  r_count;
    logic [31:0]  w_pad;
    logic         w_take;
    logic         w_push;

    assign i_byte.ready = (r_state == F_DATA) && i_cmd_ready;
    assign w_take       = i_byte.valid && i_byte.ready;
    assign w_push       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        case (r_bpos)
            2'd0:    w_pad = {C_PAD_BYTE, 24'h000000};
            2'd1:    w_pad = {r_acc[7:0], C_PAD_BYTE, 16'h0000};
            2'd2:    w_pad = {r_acc[15:0], C_PAD_BYTE, 8'h00};
            default: w_pad = {r_acc, C_PAD_BYTE};
        endcase
    end

    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd       = '{word: 32'h0, is_end: 1'b0};
        unique case (r_state)
            F_DATA: begin
                o_cmd_valid = i_byte.valid && i_byte.byte_valid && (r_bpos == 2'd3);
                o_cmd.word  = {r_acc, i_byte.data_byte};
            end
            F_PAD: begin
                o_cmd_valid = 1'b1;
                o_cmd.word  = w_pad;
            end
            F_ZERO: begin
                o_cmd_valid = 1'b1;
            end
            F_LENHI: begin
                o_cmd_valid = 1'b1;
                o_cmd.word  = r_count[60:29];
            end
            F_LENLO: begin
                o_cmd_valid  = 1'b1;
                o_cmd.word   = {r_count[28:0], 3'b000};
                o_cmd.is_end = 1'b1;
            end
            default: begin
                o_cmd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_DATA;
            r_bpos  <= 2'd0;
            r_widx  <= 4'd0;
            r_count <= 61'd0;
        end else begin
            unique case (r_state)
                F_DATA: begin
                    if (w_take) begin
                        if (i_byte.byte_valid) begin
                            r_acc   <= {r_acc[15:0], i_byte.data_byte};
                            r_bpos  <= r_bpos + 2'd1;
                            r_count <= r_count + 61'd1;
                            if (r_bpos == 2'd3) begin
                                r_widx <= r_widx + 4'd1;
                            end
                        end
                        if (i_byte.is_last) begin
                            r_state <= F_PAD;
                        end
                    end
                end
                F_PAD, F_ZERO: begin
                    if (w_push) begin
                        r_widx  <= r_widx + 4'd1;
                        r_state <= (r_widx == 4'd13) ? F_LENHI : F_ZERO;
                    end
                end
                F_LENHI: begin
                    if (w_push) begin
                        r_widx  <= r_widx + 4'd1;
                        r_state <= F_LENLO;
                    end
                end
                F_LENLO: begin
                    if (w_push) begin
                        r_widx  <= 4'd0;
                        r_bpos  <= 2'd0;
                        r_count <= 61'd0;
                        r_state <= F_DATA;
                    end
                end
                default: begin
                    r_state <= F_DATA;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sha1he_fifo.sv =====
// ----------------------------------------------------------------------------
// SHA-1 engine word queue
// Short FIFO between the front end and the compression core.
// ----------------------------------------------------------------------------
module sha1he_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  sha1he_pkg::t_cmd    i_push_cmd,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output sha1he_pkg::t_cmd    o_pop_cmd
);
    import sha1he_pkg::*;

    t_cmd              r_mem [C_QDEPTH];
    logic [C_QAW-1:0]  r_wptr;
    logic [C_QAW-1:0]  r_rptr;
    logic [C_QAW:0]    r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != (C_QAW+1)'(C_QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/sha1he_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 compression core
// Loads sixteen words, runs eighty rounds one per cycle over a rolling
// schedule window, folds into the chaining words and emits the digest.
// ----------------------------------------------------------------------------
module sha1he_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  sha1he_pkg::t_cmd    i_cmd,
    sha1he_word_if.source       o_digest
);
    import sha1he_pkg::*;

    typedef enum logic [1:0] {C_LOAD, C_ROUND, C_ADD, C_EMIT} t_cstate;

    t_cstate      r_state;
    logic [31:0]  r_w [16];
    logic [31:0]  r_h [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [6:0]   r_t;
    logic [3:0]   r_wcnt;
    logic [2:0]   r_k;
    logic         r_end;
    logic [31:0]  w_mix;
    logic [31:0]  w_wt;
    logic [31:0]  w_f;
    logic [31:0]  w_kt;
    logic [31:0]  w_sum;

    assign o_cmd_ready          = (r_state == C_LOAD);
    assign o_digest.valid       = (r_state == C_EMIT);
    assign o_digest.digest_word = r_h[0];
    assign o_digest.last_word   = (r_k == 3'd4);

    always_comb begin
        w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_wt  = (r_t < 7'd16) ? r_w[0] : {w_mix[30:0], w_mix[31]};
        if (r_t < 7'd20) begin
            w_f  = (r_b & r_c) | (~r_b & r_d);
            w_kt = C_K0;
        end else if (r_t < 7'd40) begin
            w_f  = r_b ^ r_c ^ r_d;
            w_kt = C_K1;
        end else if (r_t < 7'd60) begin
            w_f  = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_kt = C_K2;
        end else begin
            w_f  = r_b ^ r_c ^ r_d;
            w_kt = C_K3;
        end
        w_sum = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_kt + w_wt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_LOAD;
            r_wcnt  <= 4'd0;
            r_k     <= 3'd0;
            r_t     <= 7'd0;
            r_end   <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= C_H_INIT[i];
            end
        end else begin
            unique case (r_state)
                C_LOAD: begin
                    if (i_cmd_valid) begin
                        for (int i = 0; i < 15; i++) begin
                            r_w[i] <= r_w[i+1];
                        end
                        r_w[15] <= i_cmd.word;
                        r_wcnt  <= r_wcnt + 4'd1;
                        if (r_wcnt == 4'd15) begin
                            r_end   <= i_cmd.is_end;
                            r_a     <= r_h[0];
                            r_b     <= r_h[1];
                            r_c     <= r_h[2];
                            r_d     <= r_h[3];
                            r_e     <= r_h[4];
                            r_t     <= 7'd0;
                            r_state <= C_ROUND;
                        end
                    end
                end
                C_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_wt;
                    r_e     <= r_d;
                    r_d     <= r_c;
                    r_c     <= {r_b[1:0], r_b[31:2]};
                    r_b     <= r_a;
                    r_a     <= w_sum;
                    r_t     <= r_t + 7'd1;
                    if (r_t == 7'd79) begin
                        r_state <= C_ADD;
                    end
                end
                C_ADD: begin
                    r_h[0]  <= r_h[0] + r_a;
                    r_h[1]  <= r_h[1] + r_b;
                    r_h[2]  <= r_h[2] + r_c;
                    r_h[3]  <= r_h[3] + r_d;
                    r_h[4]  <= r_h[4] + r_e;
                    r_k     <= 3'd0;
                    r_state <= r_end ? C_EMIT : C_LOAD;
                end
                C_EMIT: begin
                    if (o_digest.ready) begin
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd4) begin
                            for (int i = 0; i < 5; i++) begin
                                r_h[i] <= C_H_INIT[i];
                            end
                            r_state <= C_LOAD;
                        end else begin
                            for (int i = 0; i < 4; i++) begin
                                r_h[i] <= r_h[i+1];
                            end
                        end
                    end
                end
                default: begin
                    r_state <= C_LOAD;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sha1_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streams message bytes in, one per transfer, and returns the five digest
// words H0..H4 on the output channel, last_word marking H4.
//
// Input transfer: data_byte with byte_valid, is_last ends the message
// (byte_valid 0 with is_last 1 closes a message with no further byte).
// A front end packs bytes into words and takes one byte per cycle while
// the four-entry word queue has room; at end of message it emits the
// pad, zero and length words (up to 18) before taking new bytes.
// The core loads 16 words and runs 80 rounds at one per cycle, taking
// no words while the rounds run, so the round loop sets the rate on
// long messages. The digest leaves one word per cycle while the
// receiver takes it.
// A stalled receiver holds the core on its current word; the front end
// keeps accepting bytes until the queue fills.
// Reset restores the initial chaining words and clears all counters.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sha1he_byte_if.sink     i_byte,
    sha1he_word_if.source   o_digest
);
    import sha1he_pkg::*;

    logic  w_push_valid;
    logic  w_push_ready;
    t_cmd  w_push_cmd;
    logic  w_pop_valid;
    logic  w_pop_ready;
    t_cmd  w_pop_cmd;

    sha1he_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .o_cmd_valid (w_push_valid),
        .o_cmd       (w_push_cmd),
        .i_cmd_ready (w_push_ready)
    );

    sha1he_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    sha1he_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_pop_valid),
        .o_cmd_ready (w_pop_ready),
        .i_cmd       (w_pop_cmd),
        .o_digest    (o_digest)
    );

    a_digest_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digest.valid && o_digest.ready && o_digest.last_word |=> !o_digest.valid)
        else $error("digest still valid after final word transfer");

    a_pad_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte.valid && i_byte.ready && i_byte.is_last |=> !i_byte.ready)
        else $error("byte taken while padding words are pending");

    a_core_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digest.valid |-> !w_pop_ready)
        else $error("core loading words while emitting digest");

endmodule

// ===== dv/tb_sha1he_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 engine checker
// Follows every byte transfer through a SHA-1 predictor of its own, queues
// the five digest words each message should produce and compares every
// digest word transfer against the oldest word still due.
// ----------------------------------------------------------------------------
module tb_sha1he_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_is_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_words_due
);

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] K_CH  = 32'h5A827999;
    localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] K_END = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [31:0] word;
        logic        is_h4;
    } digest_entry_t;

    logic [7:0]    blk [64];
    logic [5:0]    fill_idx;
    logic [60:0]   msg_bytes;
    logic [31:0]   chain [5];
    digest_entry_t digest_due [$];

    initial begin
        o_fail_count = 0;
        o_words_due  = 0;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                wt = rol(w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15], 1);
                w[t & 15] = wt;
            end else begin
                wt = w[t];
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PAR;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_END;
            end
            sum = rol(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = sum;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        blk[fill_idx] = b;
        fill_idx  = fill_idx + 6'd1;
        msg_bytes = msg_bytes + 61'd1;
        if (fill_idx == 6'd0)
            compress_block();
    endtask

    task automatic start_message();
        for (int i = 0; i < 5; i++)
            chain[i] = H_INIT[i];
        fill_idx  = '0;
        msg_bytes = '0;
    endtask

    task automatic finish_message();
        logic [63:0]   bit_len;
        int            pos;
        digest_entry_t ent;
        bit_len = {msg_bytes, 3'b000};
        pos = fill_idx;
        blk[pos] = PAD_BYTE;
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                blk[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            blk[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            blk[56 + i] = bit_len[63 - 8*i -: 8];
        compress_block();
        for (int i = 0; i < 5; i++) begin
            ent.word  = chain[i];
            ent.is_h4 = (i == 4);
            digest_due = {digest_due, ent};
        end
        start_message();
    endtask

    task automatic note_failure(input string what);
        if (o_fail_count < MAX_REPORTS)
            $display("[%0t] %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : p_track
        digest_entry_t want;
        if (!i_rst_n) begin
            start_message();
            digest_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_byte_valid)
                    absorb_byte(i_data_byte);
                if (i_is_last)
                    finish_message();
            end
            if (i_out_valid && i_out_ready) begin
                if (digest_due.size() == 0) begin
                    note_failure($sformatf("unexpected digest word %08h last %0b",
                                           i_digest_word, i_last_word));
                end else begin
                    want = digest_due.pop_front();
                    if (want.word !== i_digest_word || want.is_h4 !== i_last_word)
                        note_failure($sformatf(
                            "digest word: expected %08h last %0b, got %08h last %0b",
                            want.word, want.is_h4, i_digest_word, i_last_word));
                end
            end
        end
        o_words_due = digest_due.size();
    end

endmodule

// ===== dv/tb_sha1_hash_engine_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 engine testbench
// Streams directed and random messages into the engine with random gaps and
// receiver stalls, including a long output hold that backs up the input and
// a pause that lets every digest drain; a checker beside the engine predicts
// and compares each digest word.
// ----------------------------------------------------------------------------
module tb_sha1_hash_engine_unit;

    localparam int RESET_CYCLES = 11;
    localparam int GAP_MAX      = 18;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 6000;
    localparam int ITEM_TARGET  = 130;
    localparam int MIN_MESSAGES = 6;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   words_due;
    int   idle_cycles = 0;
    int   sent_items  = 0;
    logic tx_gaps     = 1'b1;
    logic rx_gaps     = 1'b1;
    logic hold_req    = 1'b0;

    sha1he_byte_if byte_if ();
    sha1he_word_if digest_if ();

    sha1_hash_engine_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_digest (digest_if)
    );

    tb_sha1he_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (byte_if.valid),
        .i_in_ready    (byte_if.ready),
        .i_data_byte   (byte_if.data_byte),
        .i_byte_valid  (byte_if.byte_valid),
        .i_is_last     (byte_if.is_last),
        .i_out_valid   (digest_if.valid),
        .i_out_ready   (digest_if.ready),
        .i_digest_word (digest_if.digest_word),
        .i_last_word   (digest_if.last_word),
        .o_fail_count  (fail_count),
        .o_words_due   (words_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_if.valid && byte_if.ready) ||
            (digest_if.valid && digest_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls, one long hold on request, none once quiet
    initial begin : p_receiver
        logic hold_done;
        hold_done = 1'b0;
        digest_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                digest_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                digest_if.ready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
            end else begin
                digest_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic bv, input logic last);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge i_clk);
        end
        byte_if.valid      <= 1'b1;
        byte_if.data_byte  <= b;
        byte_if.byte_valid <= bv;
        byte_if.is_last    <= last;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        sent_items++;
    endtask

    // close_apart ends the message with a separate item carrying no byte
    task automatic send_message(input int len, input logic close_apart);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !close_apart);
        end
        if (len == 0 || close_apart)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic drain_digests();
        byte_if.valid <= 1'b0;
        do @(posedge i_clk); while (words_due != 0);
    endtask

    initial begin : p_stimulus
        int msg_len;
        int msg_idx;
        msg_idx = 0;
        i_rst_n = 1'b0;
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = 8'h00;
        byte_if.byte_valid = 1'b0;
        byte_if.is_last    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle item, empty message, single extreme bytes
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        // "abc" closed apart, then with the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // idle item inside a message
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0);
        send_item(8'hAA, 1'b1, 1'b1);

        while (sent_items < ITEM_TARGET || msg_idx < MIN_MESSAGES) begin
            if (msg_idx == 1) begin
                msg_len = 56;
            end else if (msg_idx == 4) begin
                msg_len = 64;
            end else begin
                case ($urandom_range(0, 3))
                    0:       msg_len = $urandom_range(0, 3);
                    default: msg_len = $urandom_range(1, 6);
                endcase
            end
            send_message(msg_len, 1'($urandom_range(0, 1)));
            msg_idx++;
            if (msg_idx == 1)
                hold_req = 1'b1;
            if (msg_idx == 3)
                drain_digests();
            if (sent_items >= ITEM_TARGET - 30 && msg_idx >= MIN_MESSAGES - 3) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
        end

        drain_digests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (words_due != 0)
            $display("%0d digest words never arrived", words_due);
        if (fail_count == 0 && words_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
